FILE: rtl/gpd_pkg.sv
// Shared types and constants for the gradient predictor RGB decoder.
// No dependencies; used by every module of the decoder.
package gpd_pkg;

  // One channel is a byte; a pixel carries red, green and blue.
  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned CfgW    = 12;

  // Channel lane indexes inside a pixel word.
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  // Largest channel value; predictions are clamped to this.
  localparam logic [ChanW-1:0] ChanMax = 8'hff;

  // Packed pixel: index 0 is red, 1 green, 2 blue.
  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;

endpackage

FILE: rtl/gpd_lane.sv
// Per-channel gradient predictor and residual adder.
// Depends on gpd_pkg for the channel width and limit.
module gpd_lane
  import gpd_pkg::*;
(
  input  logic [ChanW-1:0] up_i,
  input  logic [ChanW-1:0] left_i,
  input  logic [ChanW-1:0] upleft_i,
  input  logic [ChanW-1:0] res_i,
  input  logic             col0_i,
  output logic [ChanW-1:0] chan_o
);

  logic signed [ChanW+1:0] grad;
  logic        [ChanW-1:0] est;

  // Gradient up + left - upleft spans -255..510, so two guard bits suffice.
  assign grad = $signed({2'b00, up_i}) + $signed({2'b00, left_i})
              - $signed({2'b00, upleft_i});

  // The first column uses the pixel above alone; elsewhere clamp the gradient.
  always_comb begin
    if (col0_i) begin
      est = up_i;
    end else if (grad < 0) begin
      est = '0;
    end else if (grad > $signed({2'b00, ChanMax})) begin
      est = ChanMax;
    end else begin
      est = grad[ChanW-1:0];
    end
  end

  // The residual sum wraps modulo 256.
  assign chan_o = res_i + est;

endmodule

FILE: rtl/gpd_line_buf.sv
// Line store holding the previously decoded row, one pixel per column.
// Depends on gpd_pkg for the pixel type; one write and one registered read port.
module gpd_line_buf
  import gpd_pkg::*;
#(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output pix_t             rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  pix_t             wr_data_i
);

  pix_t mem_q [Depth];
  pix_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; a same-cycle write to the address returns old data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/gradient_predictor_rgb_decoder.sv
// Top level of the gradient predictor RGB decoder.
// Depends on gpd_pkg, gpd_lane and gpd_line_buf.
//
// Usage: residual pixels enter on the in_valid_i / in_stall_o channel, one word
// per pixel in raster order, with start_rect_i high on the first pixel of each
// rectangle. Decoded pixels leave on out_valid_o / out_stall_i with row_end_o
// marking the last pixel of each row. The row width is written through
// cfg_we_i / cfg_wdata_i while the decoder is idle; 0 acts as 1 and values above
// MAX_ROW_PIXELS act as MAX_ROW_PIXELS.
// An accepted word passes through the read stage and then the output register
// before the receiver can take it. Throughput: one word per cycle while the
// receiver does not stall; the line store read is issued at the accept edge and
// a one-entry bypass covers a write to the same column in the same cycle, so
// consecutive words never wait on each other.
// Reset clears the column counter, marks the current row as a first row, sets
// the width to 1 and clears the left and upper-left pixels. The line store is
// not cleared; the first row of a rectangle never uses its read data.
// When the receiver stalls, the output register holds its word, the read stage
// fills, and in_stall_o rises only once both are occupied.
module gradient_predictor_rgb_decoder
  import gpd_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = 2048
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [ChanW-1:0] res_red_i,
  input  logic [ChanW-1:0] res_green_i,
  input  logic [ChanW-1:0] res_blue_i,
  input  logic            start_rect_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [ChanW-1:0] out_red_o,
  output logic [ChanW-1:0] out_green_o,
  output logic [ChanW-1:0] out_blue_o,
  output logic            row_end_o
);

  localparam int unsigned ColW = $clog2(MAX_ROW_PIXELS);

  // Configuration and row tracking.
  logic [CfgW-1:0] row_width_q;
  logic [ColW-1:0] col_q, col_d;
  logic            first_q, first_d;
  logic [ColW:0]   w_eff;

  // Read stage.
  logic            s1_valid_q;
  pix_t            s1_res_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_first_q;
  logic            s1_last_q;
  logic            byp_q;
  pix_t            byp_data_q;

  // Predictor context and output register.
  pix_t            left_q;
  pix_t            upleft_q;
  logic            out_valid_q;
  pix_t            out_pix_q;
  logic            out_last_q;

  logic            in_accept;
  logic            out_load;
  logic            adv;
  logic [ColW-1:0] acc_col;
  logic            acc_first;
  logic            acc_last;
  pix_t            acc_res;
  pix_t            rd_data;
  pix_t            up;
  pix_t            pix_d;
  logic            col0;

  // Handshake: the output register loads when empty or drained; the read
  // stage moves on when the output register loads.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  // Effective width, limited to 1..MAX_ROW_PIXELS.
  always_comb begin
    if (row_width_q == '0) begin
      w_eff = (ColW+1)'(1);
    end else if (32'(row_width_q) > 32'(MAX_ROW_PIXELS)) begin
      w_eff = (ColW+1)'(MAX_ROW_PIXELS);
    end else begin
      w_eff = (ColW+1)'(row_width_q);
    end
  end

  // Column and row position of the word being accepted.
  assign acc_col   = start_rect_i ? '0 : col_q;
  assign acc_first = start_rect_i ? 1'b1 : first_q;
  assign acc_last  = ({1'b0, acc_col} + (ColW+1)'(1)) >= w_eff;
  assign acc_res   = {res_blue_i, res_green_i, res_red_i};

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    if (in_accept) begin
      if (acc_last) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d   = acc_col + ColW'(1);
        first_d = acc_first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

  // Read stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Read stage payload. The bypass captures a pixel written to the same column
  // at the accept edge, which the line store read would miss.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_res_q   <= acc_res;
      s1_col_q   <= acc_col;
      s1_first_q <= acc_first;
      s1_last_q  <= acc_last;
      byp_q      <= adv && (s1_col_q == acc_col);
      byp_data_q <= pix_d;
    end
  end

  // Line store of the row above.
  gpd_line_buf #(
    .Depth (MAX_ROW_PIXELS),
    .AddrW (ColW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (acc_col),
    .rd_data_o (rd_data),
    .wr_en_i   (adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (pix_d)
  );

  // Pixel above: zero on a first row, else the bypass or the store.
  always_comb begin
    if (s1_first_q) begin
      up = '0;
    end else if (byp_q) begin
      up = byp_data_q;
    end else begin
      up = rd_data;
    end
  end

  assign col0 = (s1_col_q == '0);

  // One predictor lane per channel; their bytes merge into pix_d.
  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    gpd_lane u_lane (
      .up_i     (up[c]),
      .left_i   (left_q[c]),
      .upleft_i (upleft_q[c]),
      .res_i    (s1_res_q[c]),
      .col0_i   (col0),
      .chan_o   (pix_d[c])
    );
  end

  // Predictor context follows each decoded pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      upleft_q <= '0;
    end else if (adv) begin
      left_q   <= pix_d;
      upleft_q <= up;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q  <= pix_d;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_pix_q[ChRed];
  assign out_green_o = out_pix_q[ChGreen];
  assign out_blue_o  = out_pix_q[ChBlue];
  assign row_end_o   = out_last_q;

  // A word ending its row leaves the counter at column zero of a later row.
  a_row_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && acc_last |=> col_q == '0 && !first_q)
    else $error("row end did not wrap the column counter");

  // Every word leaving the read stage shows up in the output register.
  a_adv_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("read stage advanced without loading the output");

  // A new word never overwrites a read stage word that is not moving on.
  a_no_clobber : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !s1_valid_q || adv)
    else $error("read stage overwritten while holding a word");

  // The column of a pending word always lies inside the line store.
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> 32'(s1_col_q) < 32'(MAX_ROW_PIXELS))
    else $error("column outside the line store");

endmodule

FILE: tb/sv/tb_gradient_predictor_rgb_decoder.sv
// Self-checking testbench for gradient_predictor_rgb_decoder: drives residual words, rebuilds
// each pixel with its own gradient predictor and checks every decoded word in order.
// Depends on gpd_pkg and the decoder RTL only.
module tb_gradient_predictor_rgb_decoder;
  import gpd_pkg::*;

  localparam int unsigned MaxRowPixels = 2048;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;

  typedef struct {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             start;
  } resid_word_t;

  typedef struct {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             row_end;
  } pixel_word_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we_i     = 1'b0;
  logic [CfgW-1:0]  cfg_wdata_i  = '0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [ChanW-1:0] res_red_i    = '0;
  logic [ChanW-1:0] res_green_i  = '0;
  logic [ChanW-1:0] res_blue_i   = '0;
  logic             start_rect_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [ChanW-1:0] out_red_o;
  logic [ChanW-1:0] out_green_o;
  logic [ChanW-1:0] out_blue_o;
  logic             row_end_o;

  gradient_predictor_rgb_decoder #(
    .MAX_ROW_PIXELS(MaxRowPixels)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .res_red_i   (res_red_i),
    .res_green_i (res_green_i),
    .res_blue_i  (res_blue_i),
    .start_rect_i(start_rect_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .row_end_o   (row_end_o)
  );

  // Words waiting to be offered, and decoded pixels waiting to come out.
  resid_word_t pending_words[$];
  pixel_word_t decoded_q[$];
  resid_word_t offered_word;

  // Predictor state: the row above, the neighbors and the position in the rectangle.
  pix_t            row_above [MaxRowPixels];
  pix_t            left_pix;
  pix_t            upleft_pix;
  int unsigned     col_idx;
  logic            on_first_row;
  logic [CfgW-1:0] width_reg;

  int unsigned cyc;
  int unsigned errs;
  int unsigned words_out;
  int unsigned hold_left;
  logic        hold_done;

  // Stimulus side view of the width, used to keep every line read on written columns.
  int unsigned gen_width;
  logic        need_start;

  // Neither side idles or stalls at random inside this window.
  wire steady_window = (cyc >= 1500) && (cyc < 2300);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Run time guard.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned clamp_width(input logic [CfgW-1:0] w);
    int unsigned eff;
    eff = 32'(w);
    if (eff == 0) eff = 1;
    if (eff > MaxRowPixels) eff = MaxRowPixels;
    return eff;
  endfunction

  // Rebuild one pixel from its residuals and queue the decoded word.
  function automatic void decode_pixel(input resid_word_t rw);
    int unsigned w;
    int unsigned col;
    int          est;
    pix_t        resid;
    pix_t        up;
    pix_t        pix;
    pixel_word_t dw;
    resid[ChRed]   = rw.red;
    resid[ChGreen] = rw.green;
    resid[ChBlue]  = rw.blue;
    if (rw.start) begin
      col_idx      = 0;
      on_first_row = 1'b1;
    end
    w   = clamp_width(width_reg);
    col = (col_idx >= MaxRowPixels) ? MaxRowPixels - 1 : col_idx;
    up  = on_first_row ? '0 : row_above[col];
    for (int c = 0; c < NumChan; c++) begin
      if (col == 0) begin
        est = int'(up[c]);
      end else begin
        est = int'(up[c]) + int'(left_pix[c]) - int'(upleft_pix[c]);
        if (est > int'(ChanMax)) est = int'(ChanMax);
        else if (est < 0) est = 0;
      end
      pix[c] = resid[c] + 8'(est);
    end
    row_above[col] = pix;
    upleft_pix     = up;
    left_pix       = pix;
    dw.row_end     = (col + 1 >= w);
    if (dw.row_end) begin
      col_idx      = 0;
      on_first_row = 1'b0;
    end else begin
      col_idx = col + 1;
    end
    dw.red   = pix[ChRed];
    dw.green = pix[ChGreen];
    dw.blue  = pix[ChBlue];
    decoded_q.push_back(dw);
  endfunction

  // Sender: offers pending words, holds a stalled word, idles at random.
  always @(posedge clk_i or negedge rst_ni) begin : send_proc
    resid_word_t rw;
    logic        gap;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      left_pix     = '0;
      upleft_pix   = '0;
      col_idx      = 0;
      on_first_row = 1'b1;
      width_reg    = CfgW'(1);
    end else begin
      if (cfg_we_i) width_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) decode_pixel(offered_word);
      if (!in_valid_i || !in_stall_o) begin
        gap = !steady_window && ($urandom_range(0, 99) < 30);
        if (!gap && pending_words.size() != 0) begin
          rw           = pending_words.pop_front();
          offered_word = rw;
          res_red_i    <= rw.red;
          res_green_i  <= rw.green;
          res_blue_i   <= rw.blue;
          start_rect_i <= rw.start;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each decoded word and stalls at random, once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin : recv_proc
    pixel_word_t dw;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   = 0;
      hold_done   = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        if (decoded_q.size() == 0) begin
          $error("decoded word arrived with none expected");
          errs++;
        end else begin
          dw = decoded_q.pop_front();
          if (out_red_o !== dw.red) begin
            $error("out_red: expected %0h, got %0h", dw.red, out_red_o);
            errs++;
          end
          if (out_green_o !== dw.green) begin
            $error("out_green: expected %0h, got %0h", dw.green, out_green_o);
            errs++;
          end
          if (out_blue_o !== dw.blue) begin
            $error("out_blue: expected %0h, got %0h", dw.blue, out_blue_o);
            errs++;
          end
          if (row_end_o !== dw.row_end) begin
            $error("row_end: expected %0b, got %0b", dw.row_end, row_end_o);
            errs++;
          end
        end
      end
      if (!hold_done && words_out >= 400) begin
        hold_left = 80;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady_window && ($urandom_range(0, 99) < 30);
      end
    end
  end

  task automatic queue_word(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic st);
    resid_word_t rw;
    rw.red   = r;
    rw.green = g;
    rw.blue  = b;
    rw.start = st;
    pending_words.push_back(rw);
  endtask

  task automatic queue_random(input logic st);
    queue_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), st);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || decoded_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Width changes only once the decoder has drained. A wider row needs a new rectangle,
  // otherwise the next row would read columns that were never written.
  task automatic write_row_width(input logic [CfgW-1:0] w);
    int unsigned eff;
    wait_drained();
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    eff        = clamp_width(w);
    need_start = (eff > gen_width);
    gen_width  = eff;
    @(negedge clk_i);
  endtask

  initial begin : stim_proc
    int unsigned total;
    int unsigned n;
    int unsigned r;
    logic [CfgW-1:0] w;
    logic st;
    gen_width = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // No start flag after reset: the first row still counts as a first row.
    queue_word(8'h00, 8'h00, 8'h00, 1'b0);
    queue_word(8'hff, 8'hff, 8'hff, 1'b0);

    // Three wide rectangle whose second row drives the prediction above 255 on red
    // and below 0 on green.
    write_row_width(3);
    queue_word(8'h00, 8'hff, 8'h80, 1'b1);
    queue_word(8'hff, 8'h01, 8'hc0, 1'b0);
    queue_word(8'h55, 8'haa, 8'hff, 1'b0);
    queue_word(8'hff, 8'h01, 8'h00, 1'b0);
    queue_word(8'hff, 8'hff, 8'h7f, 1'b0);
    queue_word(8'h00, 8'h00, 8'h80, 1'b0);

    // Shrink the width while the column is already past the new last column.
    write_row_width(8);
    queue_random(1'b1);
    repeat (4) queue_random(1'b0);
    write_row_width(2);
    repeat (3) queue_random(1'b0);

    // Width zero acts as one.
    write_row_width(0);
    repeat (2) queue_random(1'b0);

    // An all ones width clamps to the line store size; stay well inside one row.
    write_row_width(12'hfff);
    queue_random(1'b1);
    repeat (40) queue_random(1'b0);

    // Random rectangles, mostly narrow, with occasional stray start flags.
    total = 0;
    while (total < 1300) begin
      r = $urandom_range(0, 99);
      if (r < 70) w = CfgW'($urandom_range(1, 16));
      else if (r < 90) w = CfgW'($urandom_range(17, 64));
      else w = CfgW'($urandom_range(0, 4095));
      write_row_width(w);
      if (gen_width <= 64)
        n = gen_width * $urandom_range(1, 5) + $urandom_range(0, gen_width - 1);
      else
        n = $urandom_range(20, 150);
      for (int i = 0; i < n; i++) begin
        if (i == 0) st = need_start || ($urandom_range(0, 3) == 0);
        else if (i % gen_width == 0) st = ($urandom_range(0, 7) == 0);
        else st = ($urandom_range(0, 59) == 0);
        queue_random(st);
      end
      total += n;
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (errs == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gpd_pkg.sv
rtl/gpd_lane.sv
rtl/gpd_line_buf.sv
rtl/gradient_predictor_rgb_decoder.sv
tb/sv/tb_gradient_predictor_rgb_decoder.sv
